// ----- rtl/dcrb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrb_pkg
// shared types and constants of the dma channel register block
// ----------------------------------------------------------------------------
package dcrb_pkg;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // register byte offsets
  localparam logic [3:0] OFS_SRC_LAST = 4'd3;
  localparam logic [3:0] OFS_DST_LAST = 4'd7;
  localparam logic [3:0] OFS_CNT_LO   = 4'd8;
  localparam logic [3:0] OFS_CNT_HI   = 4'd9;
  localparam logic [3:0] OFS_CTRL_LO  = 4'd10;
  localparam logic [3:0] OFS_CTRL_HI  = 4'd11;

  localparam logic [1:0] TIMING_IMMEDIATE = 2'd0;

  // result word, first member in the highest bits
  typedef struct packed {
    logic [1:0]  dest_step;
    logic [1:0]  source_step;
    logic        unit_size;
    logic [1:0]  timing_mode;
    logic        channel_enabled;
    logic [15:0] latched_count;
    logic [31:0] latched_dest;
    logic [31:0] latched_source;
    logic [1:0]  active_channel;
    logic        immediate_request;
    logic        transfer_armed;
    logic [7:0]  read_byte;
  } result_t;

  localparam int RESULT_W     = $bits(result_t);
  localparam int OUT_TDATA_W  = ((RESULT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - RESULT_W;
  localparam int IN_TDATA_W   = 16;

endpackage

// ----- rtl/dcrb_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrb_regs
// channel register file: byte writes, control read-back and enable latching
// ----------------------------------------------------------------------------
module dcrb_regs
  import dcrb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       req_type,
  input  logic [3:0] byte_offset,
  input  logic [7:0] write_byte,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  output result_t    result
);

  logic [31:0] source_address, source_address_next;
  logic [31:0] dest_address, dest_address_next;
  logic [15:0] count_word, count_word_next;
  logic [1:0]  dest_step_mode, dest_step_mode_next;
  logic [1:0]  source_step_mode, source_step_mode_next;
  logic        size_flag, size_flag_next;
  logic [1:0]  timing_code, timing_code_next;
  logic        repeat_flag, repeat_flag_next;
  logic        gamepak_flag, gamepak_flag_next;
  logic        irq_flag, irq_flag_next;
  logic        enable_flag, enable_flag_next;
  logic [31:0] source_latch, source_latch_next;
  logic [31:0] dest_latch, dest_latch_next;
  logic [15:0] count_latch, count_latch_next;
  logic [1:0]  channel_number;
  logic [7:0]  rd;
  logic        armed;

  always_comb begin
    source_address_next   = source_address;
    dest_address_next     = dest_address;
    count_word_next       = count_word;
    dest_step_mode_next   = dest_step_mode;
    source_step_mode_next = source_step_mode;
    size_flag_next        = size_flag;
    timing_code_next      = timing_code;
    repeat_flag_next      = repeat_flag;
    gamepak_flag_next     = gamepak_flag;
    irq_flag_next         = irq_flag;
    enable_flag_next      = enable_flag;
    source_latch_next     = source_latch;
    dest_latch_next       = dest_latch;
    count_latch_next      = count_latch;
    rd                    = 8'd0;
    armed                 = 1'b0;

    if (req_type == REQ_READ) begin
      unique case (byte_offset)
        OFS_CTRL_LO: rd = {source_step_mode[0], dest_step_mode, 5'd0};
        OFS_CTRL_HI: rd = {enable_flag, irq_flag, timing_code, gamepak_flag,
                           size_flag, repeat_flag, source_step_mode[1]};
        default:     rd = 8'd0;
      endcase
    end else begin
      priority if (byte_offset <= OFS_SRC_LAST) begin
        source_address_next[8 * byte_offset[1:0] +: 8] = write_byte;
      end else if (byte_offset <= OFS_DST_LAST) begin
        dest_address_next[8 * byte_offset[1:0] +: 8] = write_byte;
      end else if (byte_offset == OFS_CNT_LO) begin
        count_word_next[7:0] = write_byte;
      end else if (byte_offset == OFS_CNT_HI) begin
        count_word_next[15:8] = write_byte;
      end else if (byte_offset == OFS_CTRL_LO) begin
        dest_step_mode_next      = write_byte[6:5];
        source_step_mode_next[0] = write_byte[7];
      end else if (byte_offset == OFS_CTRL_HI) begin
        source_step_mode_next[1] = write_byte[0];
        repeat_flag_next         = write_byte[1];
        size_flag_next           = write_byte[2];
        gamepak_flag_next        = write_byte[3];
        timing_code_next         = write_byte[5:4];
        irq_flag_next            = write_byte[6];
        enable_flag_next         = write_byte[7];
        if (!enable_flag && write_byte[7]) begin
          armed             = 1'b1;
          source_latch_next = source_address;
          dest_latch_next   = dest_address;
          count_latch_next  = count_word;
        end
      end else begin
        // offsets past the register bytes are ignored
        armed = 1'b0;
      end
    end

    result.read_byte         = rd;
    result.transfer_armed    = armed;
    result.immediate_request = armed && (timing_code_next == TIMING_IMMEDIATE);
    result.active_channel    = (armed && (timing_code_next == TIMING_IMMEDIATE)) ?
                               channel_number : 2'd0;
    result.latched_source    = source_latch_next;
    result.latched_dest      = dest_latch_next;
    result.latched_count     = count_latch_next;
    result.channel_enabled   = enable_flag_next;
    result.timing_mode       = timing_code_next;
    result.unit_size         = size_flag_next;
    result.source_step       = source_step_mode_next;
    result.dest_step         = dest_step_mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_address   <= '0;
      dest_address     <= '0;
      count_word       <= '0;
      dest_step_mode   <= '0;
      source_step_mode <= '0;
      size_flag        <= 1'b0;
      timing_code      <= '0;
      repeat_flag      <= 1'b0;
      gamepak_flag     <= 1'b0;
      irq_flag         <= 1'b0;
      enable_flag      <= 1'b0;
      source_latch     <= '0;
      dest_latch       <= '0;
      count_latch      <= '0;
    end else if (accept) begin
      source_address   <= source_address_next;
      dest_address     <= dest_address_next;
      count_word       <= count_word_next;
      dest_step_mode   <= dest_step_mode_next;
      source_step_mode <= source_step_mode_next;
      size_flag        <= size_flag_next;
      timing_code      <= timing_code_next;
      repeat_flag      <= repeat_flag_next;
      gamepak_flag     <= gamepak_flag_next;
      irq_flag         <= irq_flag_next;
      enable_flag      <= enable_flag_next;
      source_latch     <= source_latch_next;
      dest_latch       <= dest_latch_next;
      count_latch      <= count_latch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_number <= '0;
    end else if (cfg_we) begin
      channel_number <= cfg_wdata;
    end
  end

endmodule

// ----- rtl/dcrb_out_skid.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrb_out_skid
// two-entry result buffer between the register file and the output stream
// ----------------------------------------------------------------------------
module dcrb_out_skid
  import dcrb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;
  logic    push;
  logic    pop;

  assign in_ready  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;
  assign push      = in_valid && in_ready;
  assign pop       = main_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else if (push) begin
        main_data <= in_data;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_data <= in_data;
      end else begin
        skid_data <= in_data;
      end
    end
  end

endmodule

// ----- rtl/dma_channel_register_block_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma_channel_register_block_unit
// byte-wide register front end of one dma channel
// ----------------------------------------------------------------------------
// Each bus access word is answered by one registered result word; a new word
// can be taken every cycle while the output buffer has room. The register file
// updates at acceptance and its result goes into a two-entry output buffer,
// so one more word is taken while a result waits and the input stalls only
// once both entries are full. Writing enable from 0 to 1 latches source,
// destination and count, and with immediate timing flags a start request
// carrying the configured channel number.
module dma_channel_register_block_unit
  import dcrb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_wdata,     // channel_number
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // byte_offset, write_byte
  input  logic                   s_axis_tuser,  // req_type
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // read_byte, transfer_armed, immediate_request, active_channel,
  // latched_source, latched_dest, latched_count, channel_enabled,
  // timing_mode, unit_size, source_step, dest_step
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic    accept;
  result_t result;
  result_t out_word;

  assign accept = s_axis_tvalid && s_axis_tready;

  dcrb_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .req_type    (s_axis_tuser),
    .byte_offset (s_axis_tdata[3:0]),
    .write_byte  (s_axis_tdata[11:4]),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .result      (result)
  );

  dcrb_out_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (result),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_word)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_word};

`ifndef SYNTHESIS
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a waiting result");

  a_immed_armed : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_word.immediate_request |-> out_word.transfer_armed)
    else $error("immediate request without arming");

  a_chan_only_immed : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_word.active_channel != 2'd0) |-> out_word.immediate_request)
    else $error("channel reported without immediate request");

  a_armed_enabled : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_word.transfer_armed |-> out_word.channel_enabled)
    else $error("armed result with enable clear");
`endif

endmodule

// ----- verif/tb_dma_channel_register_block_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dma_channel_register_block_unit
// self-checking bench for the dma channel register block
// ----------------------------------------------------------------------------
// Byte-wide register accesses are queued by the stimulus process and fed to
// the block by a clocked driver. Each accepted access is run through a local
// model of the register file, enable latches and start request, and the
// resulting word is queued. A clocked monitor checks every result word field
// by field. The channel number is changed between phases while the block is
// idle, and the phases cover free flow, a sparse sender, a stalling receiver
// and both together, plus one long receiver hold-off.
module tb_dma_channel_register_block_unit;
  import dcrb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS = 280;

  typedef struct packed {
    logic       req;
    logic [3:0] off;
    logic [7:0] data;
  } access_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;  // byte_offset, write_byte
  logic s_axis_tuser = 1'b0;                  // req_type
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  dma_channel_register_block_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // register file model
  logic [31:0] source_reg, dest_reg, src_latch, dst_latch;
  logic [15:0] xfer_count, cnt_latch;
  logic [1:0]  dst_step, src_step, timing, chan_id;
  logic        size_bit, repeat_bit, gamepak_bit, irq_bit, enable_bit;

  access_t access_q[$];
  result_t result_q[$];
  access_t on_bus;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int holds_served = 0;
  int hold_left = 0;
  int n_access = 0;
  int n_armed = 0;
  int n_immediate = 0;
  int n_errors = 0;
  int cycles = 0;

  function automatic result_t apply_access(access_t a);
    result_t r;
    logic was_on;
    r = '0;
    if (a.req != REQ_WRITE) begin
      if (a.off == OFS_CTRL_LO)
        r.read_byte = {src_step[0], dst_step, 5'b0};
      else if (a.off == OFS_CTRL_HI)
        r.read_byte = {enable_bit, irq_bit, timing, gamepak_bit, size_bit, repeat_bit,
                       src_step[1]};
    end else if (a.off <= OFS_SRC_LAST) begin
      source_reg[a.off[1:0]*8 +: 8] = a.data;
    end else if (a.off <= OFS_DST_LAST) begin
      dest_reg[a.off[1:0]*8 +: 8] = a.data;
    end else if (a.off == OFS_CNT_LO) begin
      xfer_count[7:0] = a.data;
    end else if (a.off == OFS_CNT_HI) begin
      xfer_count[15:8] = a.data;
    end else if (a.off == OFS_CTRL_LO) begin
      dst_step = a.data[6:5];
      src_step[0] = a.data[7];
    end else if (a.off == OFS_CTRL_HI) begin
      was_on = enable_bit;
      src_step[1] = a.data[0];
      repeat_bit = a.data[1];
      size_bit = a.data[2];
      gamepak_bit = a.data[3];
      timing = a.data[5:4];
      irq_bit = a.data[6];
      enable_bit = a.data[7];
      if (!was_on && enable_bit) begin
        r.transfer_armed = 1'b1;
        src_latch = source_reg;
        dst_latch = dest_reg;
        cnt_latch = xfer_count;
        n_armed++;
        if (timing == TIMING_IMMEDIATE) begin
          r.immediate_request = 1'b1;
          r.active_channel = chan_id;
          n_immediate++;
        end
      end
    end
    r.latched_source = src_latch;
    r.latched_dest = dst_latch;
    r.latched_count = cnt_latch;
    r.channel_enabled = enable_bit;
    r.timing_mode = timing;
    r.unit_size = size_bit;
    r.source_step = src_step;
    r.dest_step = dst_step;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        result_q.push_back(apply_access(on_bus));
        n_access++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (access_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          on_bus = access_q.pop_front();
          s_axis_tdata <= {{(IN_TDATA_W - 12){1'b0}}, on_bus.data, on_bus.off};
          s_axis_tuser <= on_bus.req;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic mismatch(string field, logic [31:0] want, logic [31:0] got);
    n_errors++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_reqs > holds_served) begin
      holds_served <= holds_served + 1;
      hold_left <= 60;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[RESULT_W-1:0]);
      if (result_q.size() == 0) begin
        mismatch("unexpected word", '0, got.read_byte);
      end else begin
        want = result_q.pop_front();
        if (got.read_byte !== want.read_byte)
          mismatch("read_byte", want.read_byte, got.read_byte);
        if (got.transfer_armed !== want.transfer_armed)
          mismatch("transfer_armed", want.transfer_armed, got.transfer_armed);
        if (got.immediate_request !== want.immediate_request)
          mismatch("immediate_request", want.immediate_request, got.immediate_request);
        if (got.active_channel !== want.active_channel)
          mismatch("active_channel", want.active_channel, got.active_channel);
        if (got.latched_source !== want.latched_source)
          mismatch("latched_source", want.latched_source, got.latched_source);
        if (got.latched_dest !== want.latched_dest)
          mismatch("latched_dest", want.latched_dest, got.latched_dest);
        if (got.latched_count !== want.latched_count)
          mismatch("latched_count", want.latched_count, got.latched_count);
        if (got.channel_enabled !== want.channel_enabled)
          mismatch("channel_enabled", want.channel_enabled, got.channel_enabled);
        if (got.timing_mode !== want.timing_mode)
          mismatch("timing_mode", want.timing_mode, got.timing_mode);
        if (got.unit_size !== want.unit_size)
          mismatch("unit_size", want.unit_size, got.unit_size);
        if (got.source_step !== want.source_step)
          mismatch("source_step", want.source_step, got.source_step);
        if (got.dest_step !== want.dest_step)
          mismatch("dest_step", want.dest_step, got.dest_step);
      end
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[dma_channel_register_block_unit] ERROR");
      $finish;
    end
  end

  function automatic void queue_access(logic req, logic [3:0] off, logic [7:0] data);
    access_t a;
    a.req = req;
    a.off = off;
    a.data = data;
    access_q.push_back(a);
  endfunction

  // mostly random, with the all-ones and all-zeros bytes now and then
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // program addresses and count, set the control word and enable, maybe read back, then disable
  function automatic int queue_programming();
    int n;
    logic [7:0] ctrl;
    n = 0;
    for (int i = 0; i <= int'(OFS_CNT_HI); i++) begin
      if ($urandom_range(0, 9) < 8) begin
        queue_access(REQ_WRITE, 4'(i), rand_byte());
        n++;
      end
    end
    queue_access(REQ_WRITE, OFS_CTRL_LO, rand_byte());
    ctrl = rand_byte();
    ctrl[7] = 1'b1;
    if ($urandom_range(0, 1))
      ctrl[5:4] = TIMING_IMMEDIATE;
    queue_access(REQ_WRITE, OFS_CTRL_HI, ctrl);
    n += 2;
    if ($urandom_range(0, 1)) begin
      queue_access(REQ_READ, OFS_CTRL_LO, rand_byte());
      queue_access(REQ_READ, OFS_CTRL_HI, rand_byte());
      n += 2;
    end
    if ($urandom_range(0, 3) == 0) begin
      queue_access(REQ_WRITE, OFS_CTRL_HI, rand_byte() | 8'h80);
      n++;
    end
    ctrl = rand_byte();
    ctrl[7] = 1'b0;
    queue_access(REQ_WRITE, OFS_CTRL_HI, ctrl);
    return n + 1;
  endfunction

  task automatic drain();
    while (access_q.size() > 0 || s_axis_tvalid || result_q.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_channel(logic [1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    chan_id = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [1:0] chan_seq[4];
    int n;
    chan_seq = '{2'd3, 2'd1, 2'd0, 2'd2};
    {source_reg, dest_reg, src_latch, dst_latch} = '0;
    {xfer_count, cnt_latch} = '0;
    {dst_step, src_step, timing, chan_id} = '0;
    {size_bit, repeat_bit, gamepak_bit, irq_bit, enable_bit} = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: reset state, extremes, re-enable, unused offsets
    queue_access(REQ_READ, OFS_CTRL_HI, 8'hFF);
    queue_access(REQ_WRITE, OFS_CTRL_HI, 8'h80);
    for (int i = 0; i < 4; i++)
      queue_access(REQ_WRITE, 4'(i), 8'hFF);
    queue_access(REQ_WRITE, 4'd4, 8'hFF);
    queue_access(REQ_WRITE, 4'd5, 8'h00);
    queue_access(REQ_WRITE, 4'd6, 8'hFF);
    queue_access(REQ_WRITE, OFS_DST_LAST, 8'h80);
    queue_access(REQ_WRITE, OFS_CNT_LO, 8'hFF);
    queue_access(REQ_WRITE, OFS_CNT_HI, 8'hFF);
    queue_access(REQ_WRITE, OFS_CTRL_LO, 8'hFF);
    queue_access(REQ_READ, OFS_CTRL_LO, 8'h00);
    queue_access(REQ_WRITE, OFS_CTRL_HI, 8'hFF);
    queue_access(REQ_WRITE, OFS_CTRL_HI, 8'h00);
    queue_access(REQ_WRITE, OFS_CTRL_HI, 8'hFF);
    queue_access(REQ_READ, OFS_CTRL_HI, 8'h00);
    queue_access(REQ_WRITE, OFS_CTRL_HI, 8'h7F);
    queue_access(REQ_WRITE, OFS_CTRL_HI, 8'h80);
    queue_access(REQ_WRITE, 4'd12, 8'hAA);
    queue_access(REQ_WRITE, 4'd15, 8'h55);
    queue_access(REQ_READ, 4'd15, 8'hFF);
    queue_access(REQ_READ, 4'd0, 8'h00);
    queue_access(REQ_READ, OFS_CNT_HI, 8'h00);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      set_channel(chan_seq[ph]);
      n = 0;
      while (n < PHASE_WORDS) begin
        if ($urandom_range(0, 3) != 0) begin
          n += queue_programming();
        end else begin
          repeat ($urandom_range(1, 6)) begin
            queue_access(1'($urandom), 4'($urandom), rand_byte());
            n++;
          end
        end
      end
      // receiver holds off while the sender keeps going
      if (ph == 0)
        hold_reqs++;
      drain();
    end

    $display("%0d register accesses checked, %0d enables latched, %0d immediate requests",
             n_access, n_armed, n_immediate);
    $display("channel ids 0 to 3, free flow, sparse sender, stalling receiver and long hold");
    if (n_errors == 0)
      $display("[dma_channel_register_block_unit] OK");
    else
      $display("[dma_channel_register_block_unit] ERROR");
    $finish;
  end

endmodule
